/* hdl/assert_macros.svh */
// Assertion helpers shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is low.
`define IFPD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, checked while reset is low.
`define IFPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

/* hdl/ifpd_pkg.sv */
package ifpd_pkg;

  localparam int MAX_BATCH_DEFAULT = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] HDR_MSG   = 8'h80;
  localparam logic [7:0] HDR_ACCEL = 8'h40;
  localparam logic [7:0] HDR_GYRO  = 8'h20;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_ABORT = 1'b1;

  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [0:0] REG_SENSOR_ID = 1'b0;

  typedef enum logic {
    PH_COUNT,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [15:0]        stamp;
    logic [7:0]         source_id;
    logic [5:0]         packet_count;
    logic [9:0]         transfer_length;
    logic               last;
  } res_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
    res_t res_a;
    res_t res_b;
  } push_t;

endpackage

/* hdl/ifpd_channels.sv */
interface ifpd_rx_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface ifpd_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic [15:0]        stamp;
  logic [7:0]         source_id;
  logic [5:0]         packet_count;
  logic [9:0]         transfer_length;
  logic               last;

  modport source (output valid, output kind, output accel_x, output accel_y,
                  output accel_z, output gyro_x, output gyro_y, output gyro_z,
                  output stamp, output source_id, output packet_count,
                  output transfer_length, output last, input ready);
  modport sink (input valid, input kind, input accel_x, input accel_y,
                input accel_z, input gyro_x, input gyro_y, input gyro_z,
                input stamp, input source_id, input packet_count,
                input transfer_length, input last, output ready);
endinterface

/* hdl/imu_fifo_packet_deframer.sv */
// IMU FIFO packet deframer.
// The rx channel carries one word per serial byte read from the sensor FIFO,
// with an opcode that marks a normal byte or an abort. Each batch begins with
// three count bytes (dummy, count high, count low); the block answers with a
// transfer request word that holds the clamped packet count and the data
// length count*16+1. The data phase then skips one dummy byte and parses
// 16-byte packets, sending one sample word for each packet with a good header,
// and closes with a batch end word that holds the good-packet count. A bad
// header suppresses the remaining samples of the batch; an abort word returns
// the block to the count phase without any result.
// Each rx word is taken into an input register and handled from there once
// a four-entry output queue has room for two results, which its results then
// enter; the first result is shown on the res channel once it is written
// into the queue. One rx word is accepted per cycle while the queue has room;
// a word that yields two results (a final sample plus the batch end) writes
// both at once, and the queue drains one result per cycle while res is ready.
// When the receiver stalls, the queue fills and rx ready falls while a word
// waits in the input register and fewer than two entries are free; nothing is
// dropped. Synchronous reset empties the queue and returns the parser to the
// count phase with sensor id zero; the sensor id is written through APB.
module imu_fifo_packet_deframer #(
  parameter int MAX_BATCH = ifpd_pkg::MAX_BATCH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  ifpd_rx_if.sink           rx,
  ifpd_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ifpd_pkg::*;

  logic [7:0] sensor_id;
  logic       room;
  push_t      push;
  res_t       head;
  logic       head_valid;

  ifpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .sensor_id (sensor_id)
  );

  ifpd_parser #(
    .MAX_BATCH (MAX_BATCH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .in_opcode (rx.opcode),
    .in_byte   (rx.rx_byte),
    .sensor_id (sensor_id),
    .room      (room),
    .push      (push)
  );

  ifpd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (head_valid),
    .out_ready (res.ready),
    .head      (head)
  );

  assign res.valid           = head_valid;
  assign res.kind            = head.kind;
  assign res.accel_x         = head.accel_x;
  assign res.accel_y         = head.accel_y;
  assign res.accel_z         = head.accel_z;
  assign res.gyro_x          = head.gyro_x;
  assign res.gyro_y          = head.gyro_y;
  assign res.gyro_z          = head.gyro_z;
  assign res.stamp           = head.stamp;
  assign res.source_id       = head.source_id;
  assign res.packet_count    = head.packet_count;
  assign res.transfer_length = head.transfer_length;
  assign res.last            = head.last;
endmodule

/* hdl/ifpd_cfg.sv */
module ifpd_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  sensor_id
);
  import ifpd_pkg::*;

  logic hit;

  // Byte address bits below the word index are ignored.
  assign hit = (paddr[2:2] == REG_SENSOR_ID);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_id <= 8'd0;
    end else if (psel && penable && pwrite && pready && hit) begin
      sensor_id <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (hit) begin
      prdata = {24'd0, sensor_id};
    end
  end
endmodule

/* hdl/ifpd_parser.sv */
`include "assert_macros.svh"

module ifpd_parser #(
  parameter int MAX_BATCH = ifpd_pkg::MAX_BATCH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [7:0]           in_byte,
  input  logic [7:0]           sensor_id,
  input  logic                 room,
  output ifpd_pkg::push_t      push
);
  import ifpd_pkg::*;

  localparam logic [15:0] CLAMP = 16'(MAX_BATCH);

  // Input register.
  logic       hold_valid;
  logic       hold_op;
  logic [7:0] hold_byte;

  // Deframer state.
  phase_t     phase, phase_next;
  logic [9:0] pos, pos_next;
  logic [7:0] cnt_hi, cnt_hi_next;
  logic [5:0] expected, expected_next;
  logic [5:0] good, good_next;
  logic       stopped, stopped_next;
  logic [7:0] pkt [15];

  logic        fire;
  logic [3:0]  idx;
  logic [15:0] count_word;
  logic [5:0]  clamped;
  logic        end_now;
  logic        sample_ok;
  logic        bad_header;
  res_t        sample_res;
  res_t        end_res;
  res_t        req_res;

  assign fire = hold_valid && room;
  assign in_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_op   <= in_opcode;
      hold_byte <= in_byte;
    end
  end

  assign idx        = pos[3:0] - 4'd1;
  assign count_word = {cnt_hi, hold_byte};
  assign clamped    = (count_word > CLAMP) ? CLAMP[5:0] : count_word[5:0];
  assign end_now    = (pos >= {expected, 4'b0000});
  assign bad_header = ((hold_byte & HDR_MSG) != 8'd0) || ((hold_byte & HDR_ACCEL) == 8'd0)
                      || ((hold_byte & HDR_GYRO) == 8'd0);
  assign sample_ok  = (pos != 10'd0) && (idx == 4'hF) && !stopped;

  // Words are big-endian; x and z axes are negated modulo 2^16.
  always_comb begin
    sample_res                 = '0;
    sample_res.kind            = KIND_SAMPLE;
    sample_res.accel_x         = 16'd0 - {pkt[1], pkt[2]};
    sample_res.accel_y         = {pkt[3], pkt[4]};
    sample_res.accel_z         = 16'd0 - {pkt[5], pkt[6]};
    sample_res.gyro_x          = 16'd0 - {pkt[7], pkt[8]};
    sample_res.gyro_y          = {pkt[9], pkt[10]};
    sample_res.gyro_z          = 16'd0 - {pkt[11], pkt[12]};
    sample_res.stamp           = {pkt[14], hold_byte};
    sample_res.source_id       = sensor_id;
    sample_res.last            = !end_now;

    end_res                    = '0;
    end_res.kind               = KIND_END;
    end_res.packet_count       = sample_ok ? good + 6'd1 : good;
    end_res.last               = 1'b1;

    req_res                    = '0;
    req_res.kind               = KIND_REQUEST;
    req_res.packet_count       = clamped;
    req_res.transfer_length    = {clamped, 4'b0001};
    req_res.last               = 1'b1;
  end

  // Next state.
  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    cnt_hi_next   = cnt_hi;
    expected_next = expected;
    good_next     = good;
    stopped_next  = stopped;
    if (fire) begin
      if (hold_op == OP_ABORT) begin
        phase_next   = PH_COUNT;
        pos_next     = 10'd0;
        good_next    = 6'd0;
        stopped_next = 1'b0;
      end else if (phase == PH_COUNT) begin
        if (pos == 10'd0) begin
          pos_next = 10'd1;
        end else if (pos == 10'd1) begin
          cnt_hi_next = hold_byte;
          pos_next    = 10'd2;
        end else begin
          expected_next = clamped;
          phase_next    = PH_DATA;
          pos_next      = 10'd0;
          good_next     = 6'd0;
          stopped_next  = 1'b0;
        end
      end else begin
        if ((pos != 10'd0) && (idx == 4'd0) && bad_header) begin
          stopped_next = 1'b1;
        end
        if (sample_ok) begin
          good_next = good + 6'd1;
        end
        if (end_now) begin
          phase_next = PH_COUNT;
          pos_next   = 10'd0;
        end else begin
          pos_next = pos + 10'd1;
        end
      end
    end
  end

  // Result words. A final sample and the batch end go out as a pair.
  always_comb begin
    push = '0;
    if (fire && (hold_op == OP_BYTE)) begin
      if (phase == PH_COUNT) begin
        if ((pos != 10'd0) && (pos != 10'd1)) begin
          push.push_a = 1'b1;
          push.res_a  = req_res;
        end
      end else begin
        if (sample_ok) begin
          push.push_a = 1'b1;
          push.res_a  = sample_res;
        end
        if (end_now) begin
          if (sample_ok) begin
            push.push_b = 1'b1;
            push.res_b  = end_res;
          end else begin
            push.push_a = 1'b1;
            push.res_a  = end_res;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_COUNT;
      pos      <= 10'd0;
      cnt_hi   <= 8'd0;
      expected <= 6'd0;
      good     <= 6'd0;
      stopped  <= 1'b0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      cnt_hi   <= cnt_hi_next;
      expected <= expected_next;
      good     <= good_next;
      stopped  <= stopped_next;
    end
  end

  // Packet bytes 0 to 14 are kept; byte 15 is used straight from the input.
  always_ff @(posedge clk) begin
    if (fire && (hold_op == OP_BYTE) && (phase == PH_DATA) && (pos != 10'd0)
        && (idx != 4'hF)) begin
      pkt[idx] <= hold_byte;
    end
  end

  `IFPD_ASSERT_IMP(a_count_pos, clk, rst, phase == PH_COUNT, pos <= 10'd2)
  `IFPD_ASSERT_IMP(a_data_pos, clk, rst, phase == PH_DATA, pos <= {expected, 4'b0000})
  `IFPD_ASSERT_IMP(a_expected_clamped, clk, rst, 1'b1, {10'd0, expected} <= CLAMP)
  `IFPD_ASSERT_IMP(a_pair_order, clk, rst, push.push_b,
                   push.push_a && push.res_a.kind == KIND_SAMPLE
                   && push.res_b.kind == KIND_END && !push.res_a.last)
endmodule

/* hdl/ifpd_out_fifo.sv */
`include "assert_macros.svh"

module ifpd_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  ifpd_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output ifpd_pkg::res_t  head
);
  import ifpd_pkg::*;

  localparam logic [FIFO_CNT_W-1:0] ROOM_MAX = FIFO_CNT_W'(FIFO_DEPTH - 2);
  localparam logic [FIFO_CNT_W-1:0] FULL_M1  = FIFO_CNT_W'(FIFO_DEPTH - 1);

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [FIFO_PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [FIFO_CNT_W-1:0] count, count_next;
  logic                  pop;

  assign room      = (count <= ROOM_MAX);
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];

  // Pointers wrap naturally since the depth is a power of two.
  always_comb begin
    wr_ptr_next = wr_ptr + FIFO_PTR_W'(push.push_a) + FIFO_PTR_W'(push.push_b);
    rd_ptr_next = rd_ptr + FIFO_PTR_W'(pop);
    count_next  = count + FIFO_CNT_W'(push.push_a) + FIFO_CNT_W'(push.push_b)
                  - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      mem[wr_ptr] <= push.res_a;
    end
    if (push.push_b) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= push.res_b;
    end
  end

  `IFPD_ASSERT_IMP(a_no_overflow_a, clk, rst, push.push_a, count <= FULL_M1)
  `IFPD_ASSERT_IMP(a_no_overflow_b, clk, rst, push.push_b, count <= ROOM_MAX)
  `IFPD_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready,
                    $stable(rd_ptr) && out_valid)
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ifpd_pkg::*;

  // The block is built with its default batch limit, and the model below
  // uses the same bound when it clamps the requested packet count.
  localparam int BATCH_CAP = MAX_BATCH_DEFAULT;

  // Register map: one 32-bit register per word address. The second address
  // lies past the map and must not disturb anything.
  localparam logic [2:0] ADDR_SENSOR_ID = {REG_SENSOR_ID, 2'b00};
  localparam logic [2:0] ADDR_BEYOND_MAP = 3'd4;

  // Words that yield nothing still pass through the input register, so
  // settle lets the clock run on for PIPE_CYCLES after the last owed word
  // before the block is treated as idle.
  localparam int PIPE_CYCLES = 6;
  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_WORDS = 1000;
  localparam int PRINT_CAP = 100;

  // Directed rows either let the model predict the outcome or carry the
  // outcome typed in, for the words whose result is plain to see.
  localparam logic PREDICT = 1'b0;
  localparam logic TYPED = 1'b1;
  localparam logic NO_WORD = 1'b0;
  localparam logic ONE_WORD = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       typed;
    logic       has_word;
    logic [1:0] kind;
    logic [5:0] pkts;
    logic [9:0] xfer_len;
  } dir_row_t;

  // The directed walk covers a zero-count batch, a one-packet batch whose
  // words sit at the int16 extremes (so the negation of -32768 wraps and the
  // sample and batch end leave on the same rx word), a count far above the
  // clamp, a bad header with bit 7 set, and an abort in the middle of the
  // data phase.
  localparam dir_row_t DIRECTED_ROWS [30] = '{
    // Zero count: dummy, high, low, then the lone data-phase dummy.
    '{OP_BYTE,  8'h00, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h00, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h00, TYPED,   ONE_WORD, KIND_REQUEST, 6'd0,  10'd1},
    '{OP_BYTE,  8'hFF, TYPED,   ONE_WORD, KIND_END,     6'd0,  10'd0},
    // One packet.
    '{OP_BYTE,  8'hFF, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h00, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h01, TYPED,   ONE_WORD, KIND_REQUEST, 6'd1,  10'd17},
    '{OP_BYTE,  8'h5A, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h7F, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h80, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h00, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h7F, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'hFF, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h00, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h01, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'hFF, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'hFF, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h00, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h00, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h80, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'h01, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'hC3, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'hFF, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'hFF, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    // Count of 0xFFFF clamps to the batch limit.
    '{OP_BYTE,  8'h00, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'hFF, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_BYTE,  8'hFF, TYPED,   ONE_WORD, KIND_REQUEST, 6'd32, 10'd513},
    '{OP_BYTE,  8'hA6, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    // Bad header, then an abort that must clear the stop for the next batch.
    '{OP_BYTE,  8'hE0, PREDICT, NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0},
    '{OP_ABORT, 8'hFF, TYPED,   NO_WORD,  KIND_SAMPLE,  6'd0,  10'd0}
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ifpd_rx_if rx();
  ifpd_res_if res();

  imu_fifo_packet_deframer #(
    .MAX_BATCH(BATCH_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Chance per cycle, in percent, that the rx side holds back a word and
  // that the result side refuses one.
  int unsigned rx_gap_pct;
  int unsigned res_stall_pct;

  int unsigned bytes_taken = 0;
  int unsigned mismatches = 0;

  // Result words the block still owes, oldest first.
  res_t result_words_due[$];

  // Our own copy of the deframer state. The packet buffer needs no reset:
  // a sample only ever reads bytes written earlier in the same packet.
  phase_t     ph = PH_COUNT;
  logic [9:0] pos = '0;
  logic [7:0] cnt_hi = '0;
  logic [5:0] n_expected = '0;
  logic [5:0] n_good = '0;
  logic       halted = 1'b0;
  logic [7:0] pkt_bytes [15];
  logic [7:0] id_reg = '0;
  res_t       step_words[$];

  task automatic report_mismatch(input string what);
    mismatches++;
    // A badly broken block would flood the log, so only the first ones print.
    if (mismatches <= PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
    end
  endtask

  // Advances the model by one rx word and leaves the words it produces in
  // step_words, in the order the block must send them.
  task automatic deframe_byte(input logic op, input logic [7:0] b);
    res_t sample;
    res_t word;
    logic have_sample;
    logic [15:0] full_count;
    logic [3:0] slot;
    step_words.delete();
    have_sample = 1'b0;
    sample = '0;
    if (op == OP_ABORT) begin
      ph = PH_COUNT;
      pos = '0;
      n_good = '0;
      halted = 1'b0;
    end else if (ph == PH_COUNT) begin
      if (pos == 10'd0) begin
        pos = 10'd1;
      end else if (pos == 10'd1) begin
        cnt_hi = b;
        pos = 10'd2;
      end else begin
        full_count = {cnt_hi, b};
        n_expected = (full_count > BATCH_CAP) ? 6'(BATCH_CAP) : full_count[5:0];
        word = '0;
        word.kind = KIND_REQUEST;
        word.packet_count = n_expected;
        word.transfer_length = {n_expected, 4'b0001};
        word.last = 1'b1;
        step_words.push_back(word);
        ph = PH_DATA;
        pos = '0;
        n_good = '0;
        halted = 1'b0;
      end
    end else begin
      // Position zero of the data phase is the dummy byte.
      if (pos != 10'd0) begin
        slot = 4'(pos - 10'd1);
        if (slot != 4'd15) begin
          pkt_bytes[slot] = b;
        end
        if (slot == 4'd0 && ((b & HDR_MSG) != 0 || (b & HDR_ACCEL) == 0 ||
                             (b & HDR_GYRO) == 0)) begin
          halted = 1'b1;
        end
        if (slot == 4'd15 && !halted) begin
          sample.kind = KIND_SAMPLE;
          sample.accel_x = 16'h0000 - {pkt_bytes[1], pkt_bytes[2]};
          sample.accel_y = {pkt_bytes[3], pkt_bytes[4]};
          sample.accel_z = 16'h0000 - {pkt_bytes[5], pkt_bytes[6]};
          sample.gyro_x = 16'h0000 - {pkt_bytes[7], pkt_bytes[8]};
          sample.gyro_y = {pkt_bytes[9], pkt_bytes[10]};
          sample.gyro_z = 16'h0000 - {pkt_bytes[11], pkt_bytes[12]};
          sample.stamp = {pkt_bytes[14], b};
          sample.source_id = id_reg;
          sample.last = 1'b1;
          have_sample = 1'b1;
          n_good = n_good + 6'd1;
        end
      end
      if (pos >= {n_expected, 4'b0000}) begin
        // The batch end follows any sample of the same byte and takes the
        // last flag from it.
        if (have_sample) begin
          sample.last = 1'b0;
          step_words.push_back(sample);
        end
        word = '0;
        word.kind = KIND_END;
        word.packet_count = n_good;
        word.last = 1'b1;
        step_words.push_back(word);
        ph = PH_COUNT;
        pos = '0;
      end else begin
        if (have_sample) begin
          step_words.push_back(sample);
        end
        pos = pos + 10'd1;
      end
    end
  endtask

  // Offers one rx word, after a random gap, and returns right after the
  // clock edge that takes it. The ready line is looked at on the falling
  // edge, where nothing is changing, and the edge that follows is the one
  // that completes the handshake.
  task automatic send_word(input logic op, input logic [7:0] b);
    logic taken;
    while ($urandom_range(99) < rx_gap_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.opcode <= op;
    rx.rx_byte <= b;
    do begin
      @(negedge clk);
      taken = rx.ready;
      @(posedge clk);
    end while (!taken);
    bytes_taken++;
  endtask

  task automatic push_word(input logic op, input logic [7:0] b);
    send_word(op, b);
    deframe_byte(op, b);
    foreach (step_words[i]) begin
      result_words_due.push_back(step_words[i]);
    end
  endtask

  // One APB transfer: setup cycle, then the access cycle, which ends at the
  // first rising edge with pready high, then psel and penable drop and the bench
  // idles so that the next transfer starts on a fresh edge.
  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
    end while (!pready);
    rdata = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sensor_id(input logic [7:0] value);
    logic [31:0] readback;
    apb_access(1'b1, ADDR_SENSOR_ID, {24'h0, value}, readback);
    id_reg = value;
    apb_access(1'b0, ADDR_SENSOR_ID, 32'h0, readback);
    if (readback !== {24'h0, value}) begin
      report_mismatch($sformatf("sensor id reads %h, should be %h", readback, value));
    end
  endtask

  // Stops sending and waits for every owed result word, then lets the
  // pipeline run empty so that words with no result are finished too.
  task automatic settle();
    rx.valid <= 1'b0;
    while (result_words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed batches with random content: small counts, mostly
  // good headers. Some batches carry a huge count and clamp, some are cut
  // short by an abort, and now and then a burst of random words with random
  // opcodes is sent and followed by an abort to get back in step.
  task automatic random_batch();
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] b;
    logic [15:0] asked;
    int n_pkts;
    int len;
    int cut_at;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(4, 1)) begin
        push_word(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
      push_word(OP_ABORT, 8'($urandom_range(255)));
      return;
    end
    hi = ($urandom_range(15) == 0) ? 8'($urandom_range(255)) : 8'h00;
    lo = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
    asked = {hi, lo};
    n_pkts = (asked > BATCH_CAP) ? BATCH_CAP : int'(asked);
    len = 4 + 16 * n_pkts;
    cut_at = -1;
    if ($urandom_range(7) == 0 || (n_pkts > 8 && $urandom_range(1) == 0)) begin
      cut_at = $urandom_range(len - 1);
    end
    for (int k = 0; k < len; k++) begin
      if (k == cut_at) begin
        push_word(OP_ABORT, pick_payload());
        return;
      end
      if (k == 1) begin
        b = hi;
      end else if (k == 2) begin
        b = lo;
      end else if (k >= 4 && (k - 4) % 16 == 0) begin
        // Headers are good most of the time: bit 7 clear, bits 6 and 5 set.
        b = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                     : {3'b011, 5'($urandom_range(31))};
      end else begin
        b = pick_payload();
      end
      push_word(OP_BYTE, b);
    end
  endtask

  // The result side accepts words at random, with the stall rate set by the
  // current stage of the run.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= ($urandom_range(99) >= res_stall_pct);
    end
  end

  // Result checking and the watchdog share one loop on the falling edge. A
  // word is compared against the oldest owed word field by field. If no word
  // moves on either channel for too long, the run is declared hung.
  initial begin : watchdog
    int unsigned quiet;
    res_t want;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
        if (result_words_due.size() == 0) begin
          report_mismatch($sformatf("result word of kind %0d with none owed", res.kind));
        end else begin
          want = result_words_due.pop_front();
          check_field("kind", 16'(res.kind), 16'(want.kind));
          check_field("accel_x", res.accel_x, want.accel_x);
          check_field("accel_y", res.accel_y, want.accel_y);
          check_field("accel_z", res.accel_z, want.accel_z);
          check_field("gyro_x", res.gyro_x, want.gyro_x);
          check_field("gyro_y", res.gyro_y, want.gyro_y);
          check_field("gyro_z", res.gyro_z, want.gyro_z);
          check_field("stamp", res.stamp, want.stamp);
          check_field("source_id", 16'(res.source_id), 16'(want.source_id));
          check_field("packet_count", 16'(res.packet_count), 16'(want.packet_count));
          check_field("transfer_length", 16'(res.transfer_length),
                      16'(want.transfer_length));
          check_field("last", 16'(res.last), 16'(want.last));
        end
      end
      if (rst || (rx.valid === 1'b1 && rx.ready === 1'b1) ||
          (res.valid === 1'b1 && res.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    dir_row_t row;
    res_t typed_word;
    logic [31:0] unused_rdata;
    int unsigned goal;
    rst = 1'b1;
    rx.valid = 1'b0;
    rx.opcode = OP_BYTE;
    rx.rx_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_gap_pct = 22;
    res_stall_pct = 86;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A write past the register map must leave the sensor id alone; the
    // readback inside set_sensor_id then confirms the real register.
    apb_access(1'b1, ADDR_BEYOND_MAP, 32'hFFFF_FFFF, unused_rdata);
    set_sensor_id(8'hA5);

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.typed == PREDICT) begin
        push_word(row.op, row.data);
      end else begin
        // The model still steps so that its state follows the block, but the
        // owed word comes from the table.
        send_word(row.op, row.data);
        deframe_byte(row.op, row.data);
        if (row.has_word == ONE_WORD) begin
          typed_word = '0;
          typed_word.kind = row.kind;
          typed_word.packet_count = row.pkts;
          typed_word.transfer_length = row.xfer_len;
          typed_word.last = 1'b1;
          result_words_due.push_back(typed_word);
        end
      end
    end

    // Three stages of random traffic: a slow receiver, then a slow sender,
    // then both at full rate. Each stage starts from an idle block with a
    // new sensor id, which also makes the sender wait for every owed word.
    for (int lap = 0; lap < 3; lap++) begin
      settle();
      case (lap)
        0: begin
          rx_gap_pct = 22;
          res_stall_pct = 86;
          set_sensor_id(8'h00);
        end
        1: begin
          rx_gap_pct = 86;
          res_stall_pct = 22;
          set_sensor_id(8'hFF);
        end
        default: begin
          rx_gap_pct = 0;
          res_stall_pct = 0;
          set_sensor_id(8'($urandom_range(255)));
        end
      endcase
      goal = bytes_taken + RANDOM_WORDS / 3;
      while (bytes_taken < goal) begin
        random_batch();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ifpd_pkg.sv
hdl/ifpd_channels.sv
hdl/ifpd_cfg.sv
hdl/ifpd_parser.sv
hdl/ifpd_out_fifo.sv
hdl/imu_fifo_packet_deframer.sv
bench/testbench.sv
